// ===== src/clp_pkg.sv =====
// Shared types, constants and helpers for the Clenshaw Legendre evaluator.
// No dependencies; imported by every module of the block.
`default_nettype none
package clp_pkg;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  localparam logic [1:0] CFG_DEGREE = 2'd0;
  localparam logic [1:0] CFG_THR_EN = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  localparam logic [47:0] ONE_Q32 = 48'h0001_0000_0000;
  localparam logic [47:0] SAT_HI  = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SAT_LO  = 48'h8000_0000_0000;

  localparam logic [1:0] MUL_LAST = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD, ST_LD_AX, ST_MUL, ST_TADD, ST_LD_AT,
    ST_AUPD, ST_BUPD, ST_FINAL, ST_WOUT
  } clp_state_t;

  typedef enum logic [1:0] {PH_AX, PH_AT, PH_AG} clp_phase_t;

  typedef struct packed {
    logic       load;
    logic       start;
    logic       rd;
    logic       mul_ld;
    clp_phase_t msel;
    logic       mul_step;
    logic [1:0] mul_k;
    logic       mul_fin;
    logic       t_add;
    logic       a_tmp;
    logic       ab_upd;
    logic       final_add;
    logic       out_wr;
  } clp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic deg_zero;
  } clp_stat_t;

  // Saturating 48-bit add; bit 48 of the result flags saturation.
  function automatic logic [48:0] sat_add(input logic [47:0] x, input logic [47:0] y);
    logic [48:0] s;
    s = {x[47], x} + {y[47], y};
    if (s[48] != s[47]) begin
      return {1'b1, (s[48] ? SAT_LO : SAT_HI)};
    end
    return {1'b0, s[47:0]};
  endfunction

endpackage
`default_nettype wire

// ===== src/clp_ctrl.sv =====
// Controller state machine sequencing the Clenshaw recurrence steps.
// Depends on clp_pkg; drives commands into clp_dp.
`default_nettype none
module clp_ctrl #(
  parameter int MAX_DEGREE = 1024,
  localparam int JW = $clog2(MAX_DEGREE + 1),
  localparam int AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_op,
  output logic                   in_stall,
  output clp_pkg::clp_cmd_t      cmd,
  output logic [AW-1:0]          addr,
  input  wire clp_pkg::clp_stat_t st,
  input  wire logic [JW-1:0]     n
);
  import clp_pkg::*;

  clp_state_t state_r, state_nxt;
  clp_phase_t phase_r, phase_nxt;
  logic [1:0] mc_r, mc_nxt;
  logic [JW-1:0] j_r, j_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_AX;
      mc_r    <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      mc_r    <= mc_nxt;
      j_r     <= j_nxt;
    end
  end

  assign addr = AW'(j_r - JW'(1));

  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    state_nxt = state_r;
    phase_nxt = phase_r;
    mc_nxt    = mc_r;
    j_nxt     = j_r;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start = 1'b1;
            j_nxt     = n;
            state_nxt = st.deg_zero ? ST_WOUT : ST_RD;
          end
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_LD_AX;
      end
      ST_LD_AX: begin
        cmd.mul_ld = 1'b1;
        cmd.msel   = PH_AX;
        phase_nxt  = PH_AX;
        mc_nxt     = '0;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        if (mc_r == MUL_LAST) begin
          cmd.mul_fin = 1'b1;
          unique case (phase_r)
            PH_AX:   state_nxt = ST_TADD;
            PH_AT:   state_nxt = (j_r == JW'(1)) ? ST_FINAL : ST_AUPD;
            PH_AG:   state_nxt = ST_BUPD;
            default: state_nxt = ST_IDLE;
          endcase
        end else begin
          cmd.mul_step = 1'b1;
          cmd.mul_k    = mc_r;
          mc_nxt       = mc_r + 2'd1;
        end
      end
      ST_TADD: begin
        cmd.t_add = 1'b1;
        state_nxt = ST_LD_AT;
      end
      ST_LD_AT: begin
        cmd.mul_ld = 1'b1;
        cmd.msel   = PH_AT;
        phase_nxt  = PH_AT;
        mc_nxt     = '0;
        state_nxt  = ST_MUL;
      end
      ST_AUPD: begin
        cmd.a_tmp  = 1'b1;
        cmd.mul_ld = 1'b1;
        cmd.msel   = PH_AG;
        phase_nxt  = PH_AG;
        mc_nxt     = '0;
        state_nxt  = ST_MUL;
      end
      ST_BUPD: begin
        cmd.ab_upd = 1'b1;
        j_nxt      = j_r - JW'(1);
        state_nxt  = ST_RD;
      end
      ST_FINAL: begin
        cmd.final_add = 1'b1;
        state_nxt     = ST_WOUT;
      end
      ST_WOUT: begin
        if (st.out_free) begin
          cmd.out_wr = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_rd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD) |-> (j_r != '0))
    else $error("table read with zero step count");
  a_mul_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && mc_r == MUL_LAST) |=> (state_r != ST_MUL))
    else $error("multiply did not finish");
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_wr |-> st.out_free)
    else $error("output overwritten");

endmodule
`default_nettype wire

// ===== src/clp_dp.sv =====
// Datapath: coefficient tables, sequential multiplier, accumulators, output register.
// Depends on clp_pkg; commanded by clp_ctrl.
`default_nettype none
module clp_dp #(
  parameter int MAX_DEGREE = 1024,
  localparam int JW = $clog2(MAX_DEGREE + 1),
  localparam int AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [46:0]        cfg_data,
  input  wire logic [10:0]        in_coeff_index,
  input  wire logic signed [31:0] in_alpha_value,
  input  wire logic signed [31:0] in_beta_value,
  input  wire logic signed [31:0] in_gamma_value,
  input  wire logic signed [31:0] in_knot,
  input  wire logic               in_last_knot,
  input  wire clp_pkg::clp_cmd_t  cmd,
  input  wire logic [AW-1:0]      addr,
  output clp_pkg::clp_stat_t      st,
  output logic [JW-1:0]           n,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      out_value,
  output logic                    out_exceeds,
  output logic                    out_batch_exceeded,
  output logic                    out_last_of_batch,
  output logic                    out_saturated
);
  import clp_pkg::*;

  logic [10:0] degree_r;
  logic        thr_en_r;
  logic [46:0] limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= '0;
      thr_en_r <= 1'b0;
      limit_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEGREE: degree_r <= cfg_data[10:0];
        CFG_THR_EN: thr_en_r <= cfg_data[0];
        CFG_LIMIT:  limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign n = (32'(degree_r) > MAX_DEGREE) ? JW'(MAX_DEGREE) : JW'(degree_r);
  assign st.deg_zero = (degree_r == 11'd0);

  logic [31:0] alpha_mem [MAX_DEGREE];
  logic [31:0] beta_mem  [MAX_DEGREE];
  logic [31:0] gamma_mem [MAX_DEGREE];
  logic [31:0] alpha_q_r, beta_q_r, gamma_q_r;
  logic        idx_ok;
  logic [AW-1:0] waddr;

  assign idx_ok = (in_coeff_index != 11'd0) && (32'(in_coeff_index) <= MAX_DEGREE);
  assign waddr  = AW'(in_coeff_index - 11'd1);

  always_ff @(posedge clk) begin
    if (cmd.load && idx_ok) begin
      alpha_mem[waddr] <= in_alpha_value;
      beta_mem[waddr]  <= in_beta_value;
      gamma_mem[waddr] <= in_gamma_value;
    end
    if (cmd.rd) begin
      alpha_q_r <= alpha_mem[addr];
      beta_q_r  <= beta_mem[addr];
      gamma_q_r <= gamma_mem[addr];
    end
  end

  logic [31:0] x_r;
  logic        last_r, zero_r, sat_r;
  logic [47:0] a_r, b_r, c_r, t_r, p_r, v_r;
  logic [47:0] mu_r, mv_r;
  logic        neg_r;
  clp_phase_t  sh_r;
  logic [95:0] acc_r;

  logic [47:0] opu, opv;
  logic [63:0] pp;
  logic [95:0] part, rnd, q;
  logic [47:0] lim;
  logic        msat;
  logic [48:0] t_sum, c_sum, v_sum;

  always_comb begin
    unique case (cmd.msel)
      PH_AX:   begin opu = {{16{alpha_q_r[31]}}, alpha_q_r}; opv = {{16{x_r[31]}}, x_r}; end
      PH_AT:   begin opu = a_r; opv = t_r; end
      PH_AG:   begin opu = a_r; opv = {{16{gamma_q_r[31]}}, gamma_q_r}; end
      default: begin opu = a_r; opv = t_r; end
    endcase
    pp   = 64'(mu_r) * 64'(mv_r[16*cmd.mul_k +: 16]);
    part = {32'd0, pp} << (16 * cmd.mul_k);
    unique case (sh_r)
      PH_AX:   begin rnd = acc_r + (96'd1 << 23); q = rnd >> 24; end
      PH_AG:   begin rnd = acc_r + (96'd1 << 27); q = rnd >> 28; end
      default: begin rnd = acc_r + (96'd1 << 31); q = rnd >> 32; end
    endcase
    lim   = neg_r ? 48'h8000_0000_0000 : SAT_HI;
    msat  = q > {48'd0, lim};
    t_sum = sat_add(p_r, {{12{beta_q_r[31]}}, beta_q_r, 4'd0});
    c_sum = sat_add(b_r, p_r);
    v_sum = sat_add(p_r, b_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_r    <= in_knot;
      last_r <= in_last_knot;
      zero_r <= st.deg_zero;
      a_r    <= ONE_Q32;
      b_r    <= '0;
      v_r    <= ONE_Q32;
      sat_r  <= 1'b0;
    end
    if (cmd.mul_ld) begin
      mu_r  <= opu[47] ? -opu : opu;
      mv_r  <= opv[47] ? -opv : opv;
      neg_r <= opu[47] ^ opv[47];
      sh_r  <= cmd.msel;
    end
    if (cmd.mul_step) begin
      acc_r <= ((cmd.mul_k == 2'd0) ? 96'd0 : acc_r) + part;
    end
    if (cmd.mul_fin) begin
      if (msat) begin
        p_r   <= neg_r ? SAT_LO : SAT_HI;
        sat_r <= 1'b1;
      end else begin
        p_r <= neg_r ? -q[47:0] : q[47:0];
      end
    end
    if (cmd.t_add) begin
      t_r <= t_sum[47:0];
      if (t_sum[48]) sat_r <= 1'b1;
    end
    if (cmd.a_tmp) begin
      c_r <= c_sum[47:0];
      if (c_sum[48]) sat_r <= 1'b1;
    end
    if (cmd.ab_upd) begin
      a_r <= c_r;
      b_r <= p_r;
    end
    if (cmd.final_add) begin
      v_r <= v_sum[47:0];
      if (v_sum[48]) sat_r <= 1'b1;
    end
  end

  logic        out_valid_r, sticky_r;
  logic [47:0] vmag;
  logic        exc;

  assign vmag = v_r[47] ? -v_r : v_r;
  assign exc  = thr_en_r && !zero_r && (vmag > {1'b0, limit_r});
  assign st.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sticky_r    <= 1'b0;
    end else if (cmd.out_wr) begin
      out_valid_r <= 1'b1;
      sticky_r    <= last_r ? 1'b0 : (sticky_r | exc);
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_wr) begin
      out_value          <= v_r;
      out_exceeds        <= exc;
      out_batch_exceeded <= sticky_r | exc;
      out_last_of_batch  <= last_r;
      out_saturated      <= sat_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== src/clenshaw_legendre_evaluator_top.sv =====
// Top level of the Clenshaw Legendre evaluator: controller plus datapath.
// Depends on clp_pkg, clp_ctrl and clp_dp.
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | op, coeff_index, coefficients, knot, last_knot
//   out_    | output    | out_valid/out_stall| value, flags
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
// A load item is written straight from the idle state. An evaluate item steps the recurrence
// down from n, the clamped degree, on one shared multiplier that forms each
// product in three 48x16 partial products and a rounding step; degree zero skips the recurrence.
// Synchronous active-low reset; tables are not cleared. A stalled result sits in
// the output register and holds back only the end of the following evaluation.
`default_nettype none
module clenshaw_legendre_evaluator_top #(
  parameter int MAX_DEGREE = 1024
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [46:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_op,
  input  wire logic [10:0]        in_coeff_index,
  input  wire logic signed [31:0] in_alpha_value,
  input  wire logic signed [31:0] in_beta_value,
  input  wire logic signed [31:0] in_gamma_value,
  input  wire logic signed [31:0] in_knot,
  input  wire logic               in_last_knot,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [47:0]      out_value,
  output logic                    out_exceeds,
  output logic                    out_batch_exceeded,
  output logic                    out_last_of_batch,
  output logic                    out_saturated
);
  import clp_pkg::*;

  localparam int JW = $clog2(MAX_DEGREE + 1);
  localparam int AW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;

  clp_cmd_t      cmd;
  clp_stat_t     st;
  logic [AW-1:0] addr;
  logic [JW-1:0] n;

  assign cfg_ready = 1'b1;

  clp_ctrl #(.MAX_DEGREE(MAX_DEGREE)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_op, .in_stall, .cmd, .addr, .st, .n
  );

  clp_dp #(.MAX_DEGREE(MAX_DEGREE)) u_dp (
    .clk, .rst_n,
    .cfg_valid(cfg_valid & cfg_ready), .cfg_index, .cfg_data,
    .in_coeff_index, .in_alpha_value, .in_beta_value, .in_gamma_value,
    .in_knot, .in_last_knot, .cmd, .addr, .st, .n,
    .out_valid, .out_stall, .out_value, .out_exceeds, .out_batch_exceeded,
    .out_last_of_batch, .out_saturated
  );

endmodule
`default_nettype wire
